@@ hdl/rsm_pkg.sv @@
package rsm_pkg;

  localparam int RowMax = 64;
  localparam int IdxW = $clog2(RowMax);
  localparam int CntW = $clog2(RowMax + 1);

  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [14:0] ClampQ88 = 15'd22528;
  localparam logic signed [25:0] C1Q24 = 26'sd11629080;
  localparam logic signed [25:0] C2Q24 = 26'sd4030332;
  localparam logic signed [25:0] C3Q24 = 26'sd931204;
  localparam logic signed [25:0] OneQ24 = 26'sd16777216;
  localparam logic [16:0] ExpMax = 17'd131071;
  localparam logic [15:0] ProbMax = 16'd65535;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last_of_row;
    logic               last_of_batch;
  } rsm_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  position;
    logic        row_done;
    logic        batch_done;
  } rsm_out_t;

endpackage

@@ hdl/row_softmax.sv @@
// Operation: a row of N items loads at one item per cycle; after the closing item the row
// is processed as N exponentials through one shared multiplier, a restoring reciprocal
// of the exponential sum, and N scaling steps that each wait for their result to be taken.
// Throughput: one row at a time; input ready is low from the closing item until the last
// result of the row is taken. Reset: asynchronous, active low; returns to an empty row.
module row_softmax (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsm_pkg::rsm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsm_pkg::rsm_out_t out_data_o
);
  import rsm_pkg::*;

  typedef enum logic [3:0] {
    SLoad, SRdS, SWaitS, SMul0, SMul1, SMul2, SFinE,
    SRecip, SRdE, SWaitE, SScale, SOut
  } state_e;

  state_e state_q;
  logic signed [15:0] score_mem [RowMax];
  logic [16:0]        exp_mem [RowMax];
  logic signed [15:0] s_rd_q;
  logic [16:0] e_rd_q;
  logic signed [15:0] max_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] i_q;
  logic [22:0] sum_q;
  logic batch_q;
  logic [6:0]  n_q;
  logic signed [25:0] f_q;
  logic signed [26:0] p_q;
  logic [47:0] rem_q;
  logic [32:0] quo_q;
  logic [5:0]  bit_q;
  logic out_valid_q;
  rsm_out_t out_q;

  // shared multiplier: 27x34 signed
  logic signed [26:0] ma;
  logic signed [33:0] mb;
  logic signed [60:0] mp;
  always_comb begin
    ma = p_q;
    mb = 34'(f_q);
    case (state_q)
      SMul0: begin ma = 27'(C3Q24); mb = 34'(f_q); end
      SScale: begin ma = $signed({10'd0, e_rd_q}); mb = $signed({1'b0, quo_q}); end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  // round-half-away of Q24 product
  logic [60:0] mag;
  logic [29:0] rmag;
  logic signed [26:0] rq;
  always_comb begin
    mag = mp[60] ? 61'(-mp) : 61'(mp);
    rmag = 30'((mag + 61'd8388608) >> 24);
    rq = mp[60] ? -27'(rmag) : 27'(rmag);
  end

  // argument reduction from stored score
  logic signed [16:0] d;
  logic [16:0] m;
  logic [31:0] u;
  logic [6:0] nn;
  logic [23:0] fr;
  always_comb begin
    d = 17'(s_rd_q) - 17'(max_q);
    m = d[16] ? 17'(-d) : 17'd0;
    if (m > 17'(ClampQ88)) m = 17'(ClampQ88);
    u = 32'(m) * 32'(Log2eQ16);
    nn = 7'(u >> 24);
    fr = u[23:0];
    if (fr > 24'h800000 || (fr == 24'h800000 && nn[0])) nn = nn + 7'd1;
  end

  // final exp shift
  logic [7:0] sh;
  logic [26:0] pp;
  logic [27:0] ev;
  logic [16:0] ex;
  always_comb begin
    pp = p_q[26] ? 27'd0 : p_q;
    sh = 8'd8 + 8'(n_q);
    ev = (28'(pp) + (28'd1 << (sh - 8'd1))) >> sh;
    ex = (ev > 28'(ExpMax)) ? ExpMax : ev[16:0];
  end

  logic [48:0] trial;
  assign trial = {rem_q, 1'b0} - 49'(sum_q);
  logic [49:0] prod;
  assign prod = 50'(mp) + 50'h80000000;
  logic [IdxW-1:0] last_i;
  assign last_i = IdxW'(cnt_q - CntW'(1));
  logic [CntW-1:0] nxt;
  logic close;
  always_comb begin
    nxt = cnt_q + CntW'(1);
    close = in_data_i.last_of_row || in_data_i.last_of_batch || nxt >= CntW'(RowMax);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SLoad && in_valid_i)
      score_mem[IdxW'(cnt_q)] <= in_data_i.score;
    if (state_q == SFinE) exp_mem[i_q] <= ex;
    s_rd_q <= score_mem[i_q];
    e_rd_q <= exp_mem[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      max_q <= 16'sh8000;
      cnt_q <= '0;
      i_q <= '0;
      sum_q <= '0;
      batch_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        SLoad: if (in_valid_i) begin
          if (in_data_i.score > max_q) max_q <= in_data_i.score;
          cnt_q <= nxt;
          if (close) begin
            batch_q <= in_data_i.last_of_batch;
            i_q <= '0;
            sum_q <= '0;
            state_q <= SRdS;
          end
        end
        SRdS: state_q <= SWaitS;
        SWaitS: begin
          n_q <= nn;
          f_q <= 26'($signed({2'b0, nn, 24'd0}) - $signed({3'b0, u}));
          state_q <= SMul0;
        end
        SMul0: begin p_q <= rq + 27'(C2Q24); state_q <= SMul1; end
        SMul1: begin p_q <= rq + 27'(C1Q24); state_q <= SMul2; end
        SMul2: begin p_q <= rq + 27'(OneQ24); state_q <= SFinE; end
        SFinE: begin
          sum_q <= sum_q + 23'(ex);
          if (i_q == last_i) begin
            rem_q <= 48'd1;
            quo_q <= '0;
            bit_q <= '0;
            state_q <= SRecip;
          end else begin
            i_q <= i_q + IdxW'(1);
            state_q <= SRdS;
          end
        end
        SRecip: begin
          // restoring division of 2^48 by sum, one quotient bit per cycle
          if (!trial[48]) begin
            rem_q <= trial[47:0];
            quo_q <= {quo_q[31:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], 1'b0};
            quo_q <= {quo_q[31:0], 1'b0};
          end
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd47) begin
            i_q <= '0;
            state_q <= SRdE;
          end
        end
        SRdE: state_q <= SWaitE;
        SWaitE: state_q <= SScale;
        SScale: begin
          out_q.probability <= (prod[49:48] != '0) ? ProbMax : prod[47:32];
          out_q.position <= 6'(i_q);
          out_q.row_done <= (i_q == last_i);
          out_q.batch_done <= (i_q == last_i) && batch_q;
          out_valid_q <= 1'b1;
          state_q <= SOut;
        end
        SOut: if (out_ready_i) begin
          if (i_q == last_i) begin
            max_q <= 16'sh8000;
            cnt_q <= '0;
            state_q <= SLoad;
          end else begin
            i_q <= i_q + IdxW'(1);
            state_q <= SRdE;
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  assign in_ready_o = (state_q == SLoad);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
